FILE: hdl/indexed_circular_list_store_unit_assert.svh
// assertion macros shared by the list store checker
`ifndef INDEXED_CIRCULAR_LIST_STORE_UNIT_ASSERT_SVH
`define INDEXED_CIRCULAR_LIST_STORE_UNIT_ASSERT_SVH

// same-cycle implication
`define ICL_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ICL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/icl_pkg.sv
// shared constants, codes and word types of the list store
package icl_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int SLOT_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int POS_W      = 5;
   localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef logic [SLOT_W-1:0]            slot_type;
   typedef logic [CNT_W-1:0]             count_type;
   typedef logic signed [DATA_WIDTH-1:0] data_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [POS_W-1:0]  position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic signed [31:0] read_value;
      logic [4:0]        entry_total;
   } rsp_type;

   typedef struct packed {
      logic     take;
      logic     release_slot;
      slot_type rel_slot;
   } alloc_ctl_type;

endpackage

FILE: hdl/icl_slot_alloc.sv
// free slot mask with lowest-free selection
module icl_slot_alloc (
   input  logic                  clock,
   input  logic                  reset,
   input  icl_pkg::alloc_ctl_type ctl,
   output icl_pkg::slot_type     free_slot
);
   import icl_pkg::*;

   logic [CAPACITY-1:0] free_ff;
   logic [CAPACITY-1:0] free_in;
   slot_type            lowest;

   always_comb begin
      lowest = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            lowest = SLOT_W'(i);
         end
      end
   end

   assign free_slot = lowest;

   always_comb begin
      free_in = free_ff;
      if (ctl.take) begin
         free_in[lowest] = 1'b0;
      end
      if (ctl.release_slot) begin
         free_in[ctl.rel_slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '1;
      end else begin
         free_ff <= free_in;
      end
   end

endmodule

FILE: hdl/indexed_circular_list_store_unit.sv
// top level: indexed circular doubly linked list store in slot memories
//
//   channel   ports                      handshake
//   request   req_word                   accepted when start && !busy
//   result    rsp_word                   valid while rsp_strobe, one cycle
//
// errors, the unused kind and an insert into an empty store answer the cycle
// after the word is accepted and leave busy low
// read and delete pass the walk and fetch states before the strobe, insert
// also link; hops are taken from the nearer end, at most CAPACITY / 2 - 1 of them;
// the link walk does one hop per cycle through the next or prev memory
// reset empties the list: slot memories are not cleared, only
// the free mask, head, tail and count are
// the next word can be started in the strobe cycle; results cannot be stalled
module indexed_circular_list_store_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  icl_pkg::req_type req_word,
   output logic             rsp_strobe,
   output icl_pkg::rsp_type rsp_word
);
   import icl_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_FETCH, S_LINK} state_type;

   // control state
   state_type     state_ff, state_in;
   logic [1:0]    op_ff, op_in;
   logic [CMP_W-1:0] pos_ff, pos_in;
   data_type      val_ff, val_in;
   logic          fwd_ff, fwd_in;
   logic          pend_ff, pend_in;
   slot_type      cur_ff, cur_in;
   slot_type      rem_ff, rem_in;
   slot_type      tgt_ff, tgt_in;
   slot_type      head_ff, head_in;
   slot_type      tail_ff, tail_in;
   count_type     count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   // slot memories, one write and one read port each
   data_type      val_mem_ff  [CAPACITY];
   slot_type      next_mem_ff [CAPACITY];
   slot_type      prev_mem_ff [CAPACITY];
   data_type      val_q_ff;
   slot_type      next_q_ff;
   slot_type      prev_q_ff;
   slot_type      raddr;
   logic          val_we, next_we, prev_we;
   slot_type      val_wa, next_wa, prev_wa;
   data_type      val_wd;
   slot_type      next_wd, prev_wd;

   alloc_ctl_type alloc_ctl;
   slot_type      free_slot;

   logic             accept;
   logic [CMP_W-1:0] pos_c;
   logic [CMP_W-1:0] cnt_c;
   slot_type         walk_cur;

   icl_slot_alloc u_alloc (
      .clock     (clock),
      .reset     (reset),
      .ctl       (alloc_ctl),
      .free_slot (free_slot)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign pos_c  = CMP_W'(req_word.position);
   assign cnt_c  = CMP_W'(count_ff);

   // walk position: once a hop read is in flight, its data is the next slot
   assign walk_cur = pend_ff ? (fwd_ff ? next_q_ff : prev_q_ff) : cur_ff;
   assign raddr    = walk_cur;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      fwd_in       = fwd_ff;
      pend_in      = pend_ff;
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      tgt_in       = tgt_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      val_we       = 1'b0;
      val_wa       = free_slot;
      val_wd       = val_ff;
      next_we      = 1'b0;
      next_wa      = free_slot;
      next_wd      = tgt_ff;
      prev_we      = 1'b0;
      prev_wa      = free_slot;
      prev_wd      = cur_ff;
      alloc_ctl    = '0;
      alloc_ctl.rel_slot = tgt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in   = req_word.kind;
               pos_in  = pos_c;
               val_in  = DATA_WIDTH'(req_word.value);
               pend_in = 1'b0;
               rsp_in.status     = STATUS_OK;
               rsp_in.read_value = '0;
               // locate setup from the nearer end
               if (pos_c < (cnt_c >> 1)) begin
                  fwd_in = 1'b1;
                  cur_in = head_ff;
                  rem_in = SLOT_W'(pos_c);
               end else begin
                  fwd_in = 1'b0;
                  cur_in = tail_ff;
                  rem_in = SLOT_W'(cnt_c - CMP_W'(1) - pos_c);
               end
               case (req_word.kind) inside
                  KIND_INSERT: begin
                     if (pos_c > cnt_c) begin
                        rsp_in.status = STATUS_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else if (32'(count_ff) == CAPACITY) begin
                        rsp_in.status = STATUS_FULL;
                        rsp_valid_in  = 1'b1;
                     end else if (count_ff == '0) begin
                        // first entry links to itself
                        val_we   = 1'b1;
                        val_wd   = DATA_WIDTH'(req_word.value);
                        next_we  = 1'b1;
                        next_wd  = free_slot;
                        prev_we  = 1'b1;
                        prev_wd  = free_slot;
                        head_in  = free_slot;
                        tail_in  = free_slot;
                        count_in = count_ff + count_type'(1);
                        alloc_ctl.take = 1'b1;
                        rsp_valid_in   = 1'b1;
                     end else begin
                        if (pos_c == cnt_c) begin
                           // append: successor is the head
                           cur_in = head_ff;
                           rem_in = '0;
                        end
                        state_in = S_WALK;
                     end
                  end
                  KIND_DELETE, KIND_READ: begin
                     if (pos_c >= cnt_c) begin
                        rsp_in.status = STATUS_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (rem_ff == '0) begin
               // target found, its links and value are read this cycle
               tgt_in   = walk_cur;
               state_in = S_FETCH;
            end else begin
               cur_in  = walk_cur;
               rem_in  = rem_ff - slot_type'(1);
               pend_in = 1'b1;
            end
         end
         S_FETCH: begin
            rsp_in.status     = STATUS_OK;
            rsp_in.read_value = '0;
            case (op_ff)
               KIND_READ: begin
                  rsp_in.read_value = 32'(val_q_ff);
                  rsp_valid_in      = 1'b1;
                  state_in          = S_IDLE;
               end
               KIND_DELETE: begin
                  if (count_ff == count_type'(1)) begin
                     head_in = '0;
                     tail_in = '0;
                  end else begin
                     // unlink: pred -> succ and succ -> pred
                     next_we = 1'b1;
                     next_wa = prev_q_ff;
                     next_wd = next_q_ff;
                     prev_we = 1'b1;
                     prev_wa = next_q_ff;
                     prev_wd = prev_q_ff;
                     if (tgt_ff == head_ff) begin
                        head_in = next_q_ff;
                     end
                     if (tgt_ff == tail_ff) begin
                        tail_in = prev_q_ff;
                     end
                  end
                  alloc_ctl.release_slot = 1'b1;
                  count_in     = count_ff - count_type'(1);
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end
               KIND_INSERT: begin
                  // neighbors point at the new slot, pred kept for the next step
                  next_we  = 1'b1;
                  next_wa  = prev_q_ff;
                  next_wd  = free_slot;
                  prev_we  = 1'b1;
                  prev_wa  = tgt_ff;
                  prev_wd  = free_slot;
                  cur_in   = prev_q_ff;
                  state_in = S_LINK;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_LINK: begin
            // new slot points at its neighbors and takes the value
            val_we  = 1'b1;
            next_we = 1'b1;
            next_wd = tgt_ff;
            prev_we = 1'b1;
            prev_wd = cur_ff;
            if (pos_ff == '0) begin
               head_in = free_slot;
            end
            if (pos_ff == cnt_c) begin
               tail_in = free_slot;
            end
            alloc_ctl.take = 1'b1;
            count_in       = count_ff + count_type'(1);
            rsp_valid_in   = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.entry_total = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff  <= op_in;
      pos_ff <= pos_in;
      val_ff <= val_in;
      fwd_ff <= fwd_in;
      cur_ff <= cur_in;
      rem_ff <= rem_in;
      tgt_ff <= tgt_in;
      rsp_ff <= rsp_in;
   end

   // slot memories, read data registered
   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem_ff[val_wa] <= val_wd;
      end
      if (next_we) begin
         next_mem_ff[next_wa] <= next_wd;
      end
      if (prev_we) begin
         prev_mem_ff[prev_wa] <= prev_wd;
      end
      val_q_ff  <= val_mem_ff[raddr];
      next_q_ff <= next_mem_ff[raddr];
      prev_q_ff <= prev_mem_ff[raddr];
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

endmodule

FILE: hdl/icl_checker.sv
// port-level checker for the list store, bound to the top level
`include "indexed_circular_list_store_unit_assert.svh"

module icl_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input icl_pkg::req_type req_word,
   input logic             rsp_strobe,
   input icl_pkg::rsp_type rsp_word
);
   import icl_pkg::*;

   logic accept_word;
   logic insert_far;
   logic full_rsp;
   logic err_rsp;

   assign accept_word = start && !busy;
   // an insert past any possible count
   assign insert_far  = accept_word && (req_word.kind == KIND_INSERT)
                        && (32'(req_word.position) > CAPACITY);
   assign full_rsp    = rsp_strobe && (rsp_word.status == STATUS_FULL);
   assign err_rsp     = rsp_strobe && (rsp_word.status != STATUS_OK);

   // an accepted word either answers next cycle or holds the block busy
   `ICL_ASSERT_NEXT(a_accept_progress, clock, reset, accept_word,
      busy || rsp_strobe, "accepted word neither answered nor busy")

   // leaving busy always delivers the result
   `ICL_ASSERT_SAME(a_done_strobe, clock, reset, !busy && $past(busy) && !$past(reset),
      rsp_strobe, "busy dropped without a result")

   // a full status only with a full store
   `ICL_ASSERT_SAME(a_full_count, clock, reset, full_rsp,
      32'(rsp_word.entry_total) == CAPACITY, "full status with room left")

   // failed requests return no data
   `ICL_ASSERT_SAME(a_err_zero, clock, reset, err_rsp,
      rsp_word.read_value == '0, "error result carries data")

   // an insert beyond any count answers a range error next cycle
   `ICL_ASSERT_NEXT(a_far_range, clock, reset, insert_far,
      rsp_strobe && (rsp_word.status == STATUS_RANGE), "far insert not rejected")

endmodule

bind indexed_circular_list_store_unit icl_checker u_checker (.*);

FILE: tb/indexed_circular_list_store_unit_test.sv
// self-checking testbench of the indexed circular list store: directed table, then random words
module indexed_circular_list_store_unit_test;
   import icl_pkg::*;

   // kind code the block leaves unused, answered as a no-op
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // random part size and phase shaping
   localparam int RANDOM_WORDS  = 1200;
   localparam int PHASE_WORDS   = 150;
   localparam int QUIET_FIRST   = 500;   // stretch of the random part with no idling
   localparam int QUIET_LAST    = 699;
   localparam int DRAIN_AT      = 400;   // sender waits for every answer here
   // covers the worst walk of CAPACITY / 2 - 1 hops and its overhead, doubled for margin
   localparam int TAIL_CYCLES   = 2 * (CAPACITY / 2 + 4) + 8;
   localparam int CYCLE_LIMIT   = 400000;

   // one row of the directed table; has_answer marks a typed-in expectation
   typedef struct packed {
      logic [1:0]         kind;
      logic [POS_W-1:0]   position;
      logic signed [31:0] value;
      logic [4:0]         reps;
      logic               has_answer;
      rsp_type            outcome;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_word;
   logic    rsp_strobe;
   rsp_type rsp_word;

   // typed-in expectation that travels with the word being offered
   logic    fixed_expect;
   rsp_type fixed_rsp;

   // answers predicted for accepted words, oldest first
   rsp_type pending_answers [$];
   int      mismatch_count = 0;
   int      cycle_count    = 0;

   // sender-side view of the entry count, used only to shape positions
   int      shadow_total = 0;

   // the predictor's own copy of the list
   data_type            slot_data [CAPACITY];
   slot_type            fwd_link  [CAPACITY];
   slot_type            back_link [CAPACITY];
   logic [CAPACITY-1:0] free_mask;
   slot_type            head_ref;
   slot_type            tail_ref;
   int                  held;

   indexed_circular_list_store_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // walk from the nearer end to the slot that holds list position p
   function automatic slot_type find_slot(input int p);
      slot_type s;
      int       i;
      if (p < held / 2) begin
         s = head_ref;
         for (i = 0; i < p; i++) s = fwd_link[s];
      end else begin
         s = tail_ref;
         for (i = 0; i < held - 1 - p; i++) s = back_link[s];
      end
      return s;
   endfunction

   // apply one accepted word to the list copy and return its answer
   function automatic rsp_type apply_to_list(input req_type w);
      rsp_type  out;
      int       p;
      int       i;
      slot_type n;
      slot_type succ;
      slot_type pred;
      out = '0;
      p   = int'(w.position);
      case (w.kind)
         KIND_INSERT: begin
            // position check wins over the full check
            if (p > held) begin
               out.status = STATUS_RANGE;
            end else if (held >= CAPACITY) begin
               out.status = STATUS_FULL;
            end else begin
               // lowest-numbered free slot
               n = '0;
               for (i = CAPACITY - 1; i >= 0; i--) begin
                  if (free_mask[i]) n = slot_type'(i);
               end
               free_mask[n] = 1'b0;
               slot_data[n] = w.value;
               if (held == 0) begin
                  fwd_link[n]  = n;
                  back_link[n] = n;
                  head_ref     = n;
                  tail_ref     = n;
               end else begin
                  // append links in front of the head, i.e. after the tail
                  succ            = (p == held) ? head_ref : find_slot(p);
                  pred            = back_link[succ];
                  fwd_link[n]     = succ;
                  back_link[n]    = pred;
                  fwd_link[pred]  = n;
                  back_link[succ] = n;
                  if (p == 0) head_ref = n;
                  if (p == held) tail_ref = n;
               end
               held++;
            end
         end
         KIND_DELETE: begin
            if (p >= held) begin
               out.status = STATUS_RANGE;
            end else begin
               n = find_slot(p);
               if (held == 1) begin
                  // emptied list parks head and tail at slot zero
                  head_ref = '0;
                  tail_ref = '0;
               end else begin
                  succ            = fwd_link[n];
                  pred            = back_link[n];
                  fwd_link[pred]  = succ;
                  back_link[succ] = pred;
                  if (n == head_ref) head_ref = succ;
                  if (n == tail_ref) tail_ref = pred;
               end
               free_mask[n] = 1'b1;
               held--;
            end
         end
         KIND_READ: begin
            if (p >= held) out.status = STATUS_RANGE;
            else out.read_value = slot_data[find_slot(p)];
         end
         default: begin
         end
      endcase
      out.entry_total = 5'(held);
      return out;
   endfunction

   // offer one word and hold it until the block takes it
   task automatic send_word(input req_type w, input logic typed_in, input rsp_type outcome);
      start        <= 1'b1;
      req_word     <= w;
      fixed_expect <= typed_in;
      fixed_rsp    <= outcome;
      @(posedge clock);
      while (busy) @(posedge clock);
      // track the count the same way the block will
      case (w.kind)
         KIND_INSERT: if (int'(w.position) <= shadow_total && shadow_total < CAPACITY)
            shadow_total++;
         KIND_DELETE: if (int'(w.position) < shadow_total) shadow_total--;
         default: begin
         end
      endcase
   endtask

   // sender goes quiet until every outstanding answer has come back
   task automatic drain_answers;
      start <= 1'b0;
      do @(negedge clock); while (pending_answers.size() != 0);
      @(posedge clock);
   endtask

   // result check first, then prediction for a word accepted at the same edge
   always @(posedge clock) begin : watch_results
      rsp_type want;
      rsp_type predicted;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: unexpected result word status %0d value %0d total %0d",
                        $time, rsp_word.status, rsp_word.read_value, rsp_word.entry_total);
               mismatch_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_word.status !== want.status) begin
                  $display("%0t: status expected %0d got %0d",
                           $time, want.status, rsp_word.status);
                  mismatch_count++;
               end
               if (rsp_word.read_value !== want.read_value) begin
                  $display("%0t: read_value expected %0d got %0d",
                           $time, want.read_value, rsp_word.read_value);
                  mismatch_count++;
               end
               if (rsp_word.entry_total !== want.entry_total) begin
                  $display("%0t: entry_total expected %0d got %0d",
                           $time, want.entry_total, rsp_word.entry_total);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            // predictor always advances, even when the answer is typed in
            predicted = apply_to_list(req_word);
            pending_answers.push_back(fixed_expect ? fixed_rsp : predicted);
         end
      end
   end

   // hard stop on a hung block
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      plan_row_type plan [$];
      plan_row_type row;
      req_type      w;
      int           r;
      int           k;
      int           pick;
      int           insert_pct;
      int           gap;

      start        <= 1'b0;
      req_word     <= '0;
      fixed_expect <= 1'b0;
      fixed_rsp    <= '0;
      reset        <= 1'b1;

      // predictor starts from an empty list
      free_mask = '1;
      head_ref  = '0;
      tail_ref  = '0;
      held      = 0;
      for (k = 0; k < CAPACITY; k++) begin
         slot_data[k] = '0;
         fwd_link[k]  = '0;
         back_link[k] = '0;
      end

      // directed table: empty store, extremes, fill to full, ends of the list
      // requests on an empty store all miss
      plan.push_back('{KIND_READ,   5'd0,  32'sd0, 5'd1, 1'b1,
                       '{STATUS_RANGE, 32'sd0, 5'd0}});
      plan.push_back('{KIND_DELETE, 5'd0,  32'sd0, 5'd1, 1'b1,
                       '{STATUS_RANGE, 32'sd0, 5'd0}});
      plan.push_back('{KIND_INSERT, 5'd1,  32'sd5, 5'd1, 1'b1,
                       '{STATUS_RANGE, 32'sd0, 5'd0}});
      // extreme words at the head and appended at the end
      plan.push_back('{KIND_INSERT, 5'd0,  32'sh7fffffff, 5'd1, 1'b1,
                       '{STATUS_OK, 32'sd0, 5'd1}});
      plan.push_back('{KIND_INSERT, 5'd1,  32'sh80000000, 5'd1, 1'b1,
                       '{STATUS_OK, 32'sd0, 5'd2}});
      // position zero is the head entry
      plan.push_back('{KIND_READ,   5'd0,  32'sd0, 5'd1, 1'b1,
                       '{STATUS_OK, 32'sh7fffffff, 5'd2}});
      plan.push_back('{KIND_READ,   5'd1,  32'sd0, 5'd1, 1'b1,
                       '{STATUS_OK, 32'sh80000000, 5'd2}});
      // unused kind is a no-op
      plan.push_back('{KIND_UNUSED, 5'd31, -32'sd1, 5'd1, 1'b1,
                       '{STATUS_OK, 32'sd0, 5'd2}});
      // fill the middle until the store is full
      plan.push_back('{KIND_INSERT, 5'd1,  32'sh5a5a5a50, 5'd14, 1'b0, '0});
      // full store: valid position reports full, bad position reports range
      plan.push_back('{KIND_INSERT, 5'd16, 32'sd1, 5'd1, 1'b1,
                       '{STATUS_FULL, 32'sd0, 5'd16}});
      plan.push_back('{KIND_INSERT, 5'd17, 32'sd1, 5'd1, 1'b1,
                       '{STATUS_RANGE, 32'sd0, 5'd16}});
      plan.push_back('{KIND_READ,   5'd15, 32'sd0, 5'd1, 1'b0, '0});
      plan.push_back('{KIND_READ,   5'd16, 32'sd0, 5'd1, 1'b1,
                       '{STATUS_RANGE, 32'sd0, 5'd16}});
      // remove the tail, then the head
      plan.push_back('{KIND_DELETE, 5'd15, 32'sd0, 5'd1, 1'b1,
                       '{STATUS_OK, 32'sd0, 5'd15}});
      plan.push_back('{KIND_DELETE, 5'd0,  32'sd0, 5'd1, 1'b1,
                       '{STATUS_OK, 32'sd0, 5'd14}});
      plan.push_back('{KIND_READ,   5'd0,  32'sd0, 5'd1, 1'b0, '0});
      plan.push_back('{KIND_DELETE, 5'd31, 32'sd0, 5'd1, 1'b1,
                       '{STATUS_RANGE, 32'sd0, 5'd14}});

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         row = plan[i];
         for (r = 0; r < int'(row.reps); r++) begin
            w.kind     = row.kind;
            w.position = row.position;
            w.value    = row.value + r;
            send_word(w, row.has_answer, row.outcome);
         end
      end

      // settle the directed part before the random traffic
      drain_answers();

      insert_pct = 85;
      for (k = 0; k < RANDOM_WORDS; k++) begin
         // switch between filling, balanced and draining phases
         if (k % PHASE_WORDS == 0 && k != 0) begin
            case ($urandom_range(2))
               0:       insert_pct = 85;
               1:       insert_pct = 50;
               default: insert_pct = 20;
            endcase
         end
         if (k == DRAIN_AT) drain_answers();

         pick = $urandom_range(99);
         if (pick < 3) begin
            w.kind = KIND_UNUSED;
         end else if ($urandom_range(99) < insert_pct) begin
            w.kind = KIND_INSERT;
         end else begin
            w.kind = ($urandom_range(1) == 0) ? KIND_DELETE : KIND_READ;
         end

         // mostly valid positions, some noise across the whole field
         if (pick >= 90) begin
            w.position = POS_W'($urandom_range(31));
         end else if (w.kind == KIND_INSERT) begin
            w.position = POS_W'($urandom_range(shadow_total));
         end else begin
            w.position = (shadow_total == 0) ? '0 : POS_W'($urandom_range(shadow_total - 1));
         end

         // words at the signed extremes, zero and all ones now and then
         case ($urandom_range(19))
            0:       w.value = 32'sh7fffffff;
            1:       w.value = 32'sh80000000;
            2:       w.value = '0;
            3:       w.value = '1;
            default: w.value = $urandom;
         endcase

         // random idle gap, none inside the quiet stretch
         if ((k < QUIET_FIRST || k > QUIET_LAST) && $urandom_range(99) < 15) begin
            gap   = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         send_word(w, 1'b0, '0);
      end

      // wait for the last answers, then let the walk time run out
      drain_answers();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
